@@ hw/rtl/tcce_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the text console cursor engine
package tcce_pkg;

    typedef logic [3:0] t_func;
    typedef logic [1:0] t_commit;

    // command codes
    localparam t_func F_DRAW    = 4'd0;
    localparam t_func F_ADVANCE = 4'd1;
    localparam t_func F_RETREAT = 4'd2;
    localparam t_func F_NEWLINE = 4'd3;
    localparam t_func F_TAB     = 4'd4;
    localparam t_func F_CLEAR   = 4'd5;
    localparam t_func F_SCROLL  = 4'd6;
    localparam t_func F_SETPOS  = 4'd7;
    localparam t_func F_READ    = 4'd8;

    // cursor commit selects
    localparam t_commit CM_NONE = 2'd0;
    localparam t_commit CM_WORK = 2'd1;
    localparam t_commit CM_ZERO = 2'd2;

    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] SCROLL_FILL = 8'd3;
    localparam int         TAB_STEP    = 8;

    typedef struct packed {
        logic    load;
        logic    draw_wr;
        logic    wrap_step;
        logic    unwrap_step;
        logic    adv_scroll;
        t_commit commit;
        logic    sweep_start;
        logic    fill_sel3;
        logic    copy_step;
        logic    fill_step;
        logic    rd_issue;
        logic    out_load;
        logic    cell_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic wcol_ge_cols;
        logic wcol_neg;
        logic wrow_zero;
        logic wrow_ge_rows;
        logic last_copy;
        logic last_fill;
    } t_dp_stat;

endpackage

@@ hw/rtl/tcce_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine of the text console cursor engine
module tcce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tcce_pkg::t_func    i_func,
    input  logic               i_stall,
    input  tcce_pkg::t_dp_stat i_stat,
    output tcce_pkg::t_dp_cmd  o_cmd,
    output logic               o_stall,
    output logic               o_valid
);
    import tcce_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_WRAP   = 4'd2;
    localparam logic [3:0] S_UNWRAP = 4'd3;
    localparam logic [3:0] S_COPY   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state, n_state;
    t_func      r_func, n_func;
    logic       r_auto, n_auto;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    t_dp_cmd    cmd;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_func  = r_func;
        n_auto  = r_auto;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_func   = i_func;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_func)
                    F_DRAW: begin
                        cmd.draw_wr = 1'b1;
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    F_ADVANCE, F_NEWLINE, F_TAB, F_SETPOS: begin
                        n_state = S_WRAP;
                    end
                    F_RETREAT: begin
                        n_state = S_UNWRAP;
                    end
                    F_CLEAR: begin
                        cmd.sweep_start = 1'b1;
                        n_auto          = 1'b0;
                        n_state         = S_FILL;
                    end
                    F_SCROLL: begin
                        cmd.sweep_start = 1'b1;
                        n_auto          = 1'b0;
                        n_state         = S_COPY;
                    end
                    F_READ: begin
                        cmd.rd_issue = 1'b1;
                        n_state      = S_RDWAIT;
                    end
                    default: begin
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_WRAP: begin
                if (i_stat.wcol_ge_cols) begin
                    cmd.wrap_step = 1'b1;
                end else if (i_stat.wrow_ge_rows && (r_func != F_SETPOS)) begin
                    cmd.sweep_start = 1'b1;
                    cmd.fill_sel3   = 1'b1;
                    cmd.adv_scroll  = 1'b1;
                    n_auto          = 1'b1;
                    n_state         = S_COPY;
                end else begin
                    cmd.commit = CM_WORK;
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_UNWRAP: begin
                if (i_stat.wcol_neg && !i_stat.wrow_zero) begin
                    cmd.unwrap_step = 1'b1;
                end else begin
                    cmd.commit = i_stat.wcol_neg ? CM_ZERO : CM_WORK;
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                cmd.copy_step = 1'b1;
                if (i_stat.last_copy) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (i_stat.last_fill) begin
                    n_state = r_auto ? S_WRAP : S_DONE;
                end
            end
            S_RDWAIT: begin
                cmd.cell_sel = 1'b1;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_func      <= F_DRAW;
            r_auto      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_func      <= n_func;
            r_auto      <= n_auto;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ hw/rtl/tcce_dpath.sv @@
`timescale 1ns / 1ps
// datapath of the text console cursor engine: cursor, working regs, sweep, cell store
module tcce_dpath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcce_pkg::t_dp_cmd  i_cmd,
    input  tcce_pkg::t_func    i_func,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_color_attr,
    input  logic [7:0]         i_move_count,
    input  logic [4:0]         i_target_row,
    input  logic [6:0]         i_target_col,
    output tcce_pkg::t_dp_stat o_stat,
    output logic [4:0]         o_cursor_row,
    output logic [6:0]         o_cursor_col,
    output logic [15:0]        o_cell_value
);
    import tcce_pkg::*;

    localparam int CW   = $clog2(COLS);
    localparam int RW   = $clog2(ROWS);
    localparam int N    = ROWS * COLS;
    localparam int NC   = (ROWS - 1) * COLS;
    localparam int AW   = $clog2(N);
    localparam int WRW  = ((RW > 5) ? RW : 5) + 2;
    localparam int WCW  = ((CW > 8) ? CW : 8) + 2;
    localparam int OMAX = 31 * COLS + 127;
    localparam int OW   = $clog2(((OMAX > N) ? OMAX : N) + 1);

    localparam logic signed [WCW-1:0] COLS_W   = WCW'(COLS);
    localparam logic        [WCW-1:0] TAB_MASK = WCW'(TAB_STEP - 1);

    logic [RW-1:0]         r_cur_row, n_cur_row;
    logic [CW-1:0]         r_cur_col, n_cur_col;
    logic [WRW-1:0]        r_wrow, n_wrow;
    logic signed [WCW-1:0] r_wcol, n_wcol;
    logic [7:0]            r_char, r_attr;
    logic [4:0]            r_trow;
    logic [6:0]            r_tcol;
    logic [AW-1:0]         r_addr;
    logic                  r_cp_valid;
    logic [AW-1:0]         r_cp_addr;
    logic [15:0]           r_fill;
    logic [15:0]           r_rd_data;
    logic [4:0]            r_out_row;
    logic [6:0]            r_out_col;
    logic [15:0]           r_out_cell;
    logic [15:0]           mem [N];

    logic signed [WCW-1:0] cur_col_w;
    logic signed [WCW-1:0] cnt_w;
    logic [AW-1:0]         cur_addr;
    logic [OW-1:0]         toff;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  wrow_ge;
    logic [WRW-1:0]        out_row_ext;
    logic [WCW-1:0]        out_col_ext;

    assign cur_col_w = {{(WCW-CW){1'b0}}, r_cur_col};
    assign cnt_w     = {{(WCW-8){1'b0}}, i_move_count};
    assign cur_addr  = AW'(r_cur_row) * AW'(COLS) + AW'(r_cur_col);
    assign toff      = OW'(r_trow) * OW'(COLS) + OW'(r_tcol);
    assign wrow_ge   = (r_wrow >= WRW'(ROWS));

    // working cursor
    always_comb begin
        n_wrow = r_wrow;
        n_wcol = r_wcol;
        if (i_cmd.load) begin
            n_wrow = (i_func == F_SETPOS) ? WRW'(i_target_row) : WRW'(r_cur_row);
            case (i_func)
                F_ADVANCE: n_wcol = cur_col_w + cnt_w;
                F_RETREAT: n_wcol = cur_col_w - cnt_w;
                F_NEWLINE: n_wcol = COLS_W;
                F_TAB:     n_wcol = (cur_col_w | TAB_MASK) + WCW'(1);
                F_SETPOS:  n_wcol = {{(WCW-7){1'b0}}, i_target_col};
                default:   n_wcol = cur_col_w;
            endcase
        end else if (i_cmd.wrap_step) begin
            n_wcol = r_wcol - COLS_W;
            n_wrow = r_wrow + WRW'(1);
        end else if (i_cmd.unwrap_step) begin
            n_wcol = r_wcol + COLS_W;
            n_wrow = r_wrow - WRW'(1);
        end else if (i_cmd.adv_scroll) begin
            n_wcol = '0;
            n_wrow = r_wrow - WRW'(1);
        end
    end

    // cursor commit, saturated to the last cell
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        case (i_cmd.commit)
            CM_WORK: begin
                if (wrow_ge) begin
                    n_cur_row = RW'(ROWS - 1);
                    n_cur_col = CW'(COLS - 1);
                end else begin
                    n_cur_row = r_wrow[RW-1:0];
                    n_cur_col = r_wcol[CW-1:0];
                end
            end
            CM_ZERO: begin
                n_cur_row = '0;
                n_cur_col = '0;
            end
            default: begin
                n_cur_row = r_cur_row;
                n_cur_col = r_cur_col;
            end
        endcase
    end

    assign out_row_ext = WRW'(n_cur_row);
    assign out_col_ext = WCW'(n_cur_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_cp_valid <= i_cmd.copy_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrow    <= n_wrow;
        r_wcol    <= n_wcol;
        r_cp_addr <= r_addr;
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_attr <= i_color_attr;
            r_trow <= i_target_row;
            r_tcol <= i_target_col;
        end
        if (i_cmd.sweep_start) begin
            r_addr <= '0;
            r_fill <= {(i_cmd.fill_sel3 ? SCROLL_FILL : r_attr), BLANK_CHAR};
        end else if (i_cmd.copy_step || i_cmd.fill_step) begin
            r_addr <= r_addr + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_row  <= out_row_ext[4:0];
            r_out_col  <= out_col_ext[6:0];
            r_out_cell <= i_cmd.cell_sel ? r_rd_data : 16'd0;
        end
    end

    // cell store: one write port, one registered read port
    assign rd_en   = i_cmd.copy_step || i_cmd.rd_issue;
    assign rd_addr = i_cmd.copy_step ? (r_addr + AW'(COLS)) :
                     ((toff > OW'(N - 1)) ? AW'(N - 1) : toff[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (r_cp_valid) begin
            mem[r_cp_addr] <= r_rd_data;
        end else if (i_cmd.fill_step) begin
            mem[r_addr] <= r_fill;
        end else if (i_cmd.draw_wr) begin
            mem[cur_addr] <= {r_attr, r_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_stat.wcol_ge_cols = !r_wcol[WCW-1] && (r_wcol[WCW-2:0] >= COLS_W[WCW-2:0]);
    assign o_stat.wcol_neg     = r_wcol[WCW-1];
    assign o_stat.wrow_zero    = (r_wrow == '0);
    assign o_stat.wrow_ge_rows = wrow_ge;
    assign o_stat.last_copy    = (r_addr == AW'(NC - 1));
    assign o_stat.last_fill    = (r_addr == AW'(N - 1));

    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_value = r_out_cell;

endmodule

@@ hw/rtl/text_console_cursor_engine.sv @@
`timescale 1ns / 1ps
// top level of the text console cursor engine
//
// channel   direction  handshake            payload
// command   in         i_valid / o_stall    i_func i_char_code i_color_attr i_move_count
//                                           i_target_row i_target_col
// result    out        o_valid / i_stall    o_cursor_row o_cursor_col o_cell_value
//
// steps of a transaction after the accept:
//   draw and unused codes load their result from the execute step, read cell waits on the read
//   advance, retreat, newline, tab, set position add one step per row wrap of the column
//   clear fills every cell; scroll copies the rows up, drains, then fills the bottom row;
//   each scroll caused by an advance adds such a sweep; the sweeps walk one cell per cycle
// reset puts the cursor at 0,0; the cell store is not cleared and reads as undefined
// until written
// a new command is taken once the previous one has left its result in the output
// register; a stalled result only holds the engine at its final step
module text_console_cursor_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color_attr,
    input  logic [7:0]  i_move_count,
    input  logic [4:0]  i_target_row,
    input  logic [6:0]  i_target_col,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [15:0] o_cell_value
);
    import tcce_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller: sequences each transaction, owns the output valid
    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // datapath: cursor, wrap arithmetic, store sweeps, output payload register
    tcce_dpath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_color_attr (i_color_attr),
        .i_move_count (i_move_count),
        .i_target_row (i_target_row),
        .i_target_col (i_target_col),
        .o_stat       (stat),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_value (o_cell_value)
    );

`ifndef ASSERT_OFF
    // an accepted command raises the stall in the following cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("command accepted while engine busy");

    // the last delayed copy write has drained before fill writes start
    a_fill_after_drain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.fill_step |-> !$past(cmd.copy_step)
    ) else $error("fill write collides with pending copy write");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall)
    ) else $error("result overwritten while stalled");

    // the reported cursor stays on the screen
    a_cursor_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_cursor_row) < ROWS) && (32'(o_cursor_col) < COLS))
    ) else $error("cursor outside the screen");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the text console cursor engine
module tb;

    import tcce_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    // random part of the command stream
    localparam int RANDOM_CMDS = 450;
    // near the end of the stream both sides stop idling
    localparam int QUIET_TAIL  = 40;

    // one command transaction as the driver presents it
    typedef struct {
        t_func       func;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [7:0]  count;
        logic [4:0]  trow;
        logic [6:0]  tcol;
        bit          drain_first;  // hold off until every result is back
    } t_console_cmd;

    // one result transaction
    typedef struct {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [15:0] cell_value;
    } t_console_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [3:0]  i_func       = '0;
    logic [7:0]  i_char_code  = '0;
    logic [7:0]  i_color_attr = '0;
    logic [7:0]  i_move_count = '0;
    logic [4:0]  i_target_row = '0;
    logic [6:0]  i_target_col = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [15:0] o_cell_value;

    text_console_cursor_engine #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_color_attr (i_color_attr),
        .i_move_count (i_move_count),
        .i_target_row (i_target_row),
        .i_target_col (i_target_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_value (o_cell_value)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow copy of the console: cell store and cursor
    // ------------------------------------------------------------------
    logic [15:0] shadow_cells [CELLS];
    int          shadow_row;
    int          shadow_col;

    t_console_cmd    pending_cmds [$];
    t_console_result expected_results [$];

    int error_count = 0;
    int sent_count  = 0;
    int total_cmds  = 0;

    // every row moves up by one, the freed bottom row gets blanks in the given color
    function automatic void shift_rows_up(input logic [7:0] attr);
        int i;
        for (i = 0; i < (ROWS - 1) * COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
        for (i = (ROWS - 1) * COLS; i < CELLS; i++)
            shadow_cells[i] = {attr, BLANK_CHAR};
    endfunction

    // forward motion: the column wraps into rows, overflow past the bottom scrolls
    function automatic void cursor_forward(input int count);
        int row;
        int col;
        row = shadow_row;
        col = shadow_col + count;
        while (col >= COLS) begin
            row++;
            col -= COLS;
        end
        while (row >= ROWS) begin
            shift_rows_up(SCROLL_FILL);
            row--;
            col = 0;
        end
        shadow_row = row;
        shadow_col = col;
    endfunction

    // backward motion: going above the top row lands at home
    function automatic void cursor_back(input int count);
        int row;
        int col;
        row = shadow_row;
        col = shadow_col - count;
        while (col < 0) begin
            row--;
            col += COLS;
        end
        if (row < 0) begin
            row = 0;
            col = 0;
        end
        shadow_row = row;
        shadow_col = col;
    endfunction

    // linear cell address of a target, saturated at the last cell
    function automatic int clamped_offset(input logic [4:0] trow, input logic [6:0] tcol);
        int off;
        off = int'(trow) * COLS + int'(tcol);
        if (off > CELLS - 1)
            off = CELLS - 1;
        return off;
    endfunction

    // applies one command to the shadow console and returns what the block must answer
    function automatic t_console_result console_apply(input t_console_cmd cmd);
        t_console_result res;
        int off;
        int i;
        res.cell_value = '0;
        case (cmd.func)
            F_DRAW:    shadow_cells[shadow_row * COLS + shadow_col] = {cmd.attr, cmd.ch};
            F_ADVANCE: cursor_forward(int'(cmd.count));
            F_RETREAT: cursor_back(int'(cmd.count));
            F_NEWLINE: cursor_forward(COLS - shadow_col);
            F_TAB:     cursor_forward(TAB_STEP - (shadow_col % TAB_STEP));
            F_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    shadow_cells[i] = {cmd.attr, BLANK_CHAR};
            end
            F_SCROLL:  shift_rows_up(cmd.attr);
            F_SETPOS: begin
                off = clamped_offset(cmd.trow, cmd.tcol);
                shadow_row = off / COLS;
                shadow_col = off % COLS;
            end
            F_READ:    res.cell_value = shadow_cells[clamped_offset(cmd.trow, cmd.tcol)];
            default: ;  // unused codes leave everything as it is
        endcase
        res.row = 5'(shadow_row);
        res.col = 7'(shadow_col);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic t_console_cmd make_cmd(input t_func func, input logic [7:0] ch,
                                              input logic [7:0] attr, input logic [7:0] count,
                                              input logic [4:0] trow, input logic [6:0] tcol);
        t_console_cmd c;
        c.func        = func;
        c.ch          = ch;
        c.attr        = attr;
        c.count       = count;
        c.trow        = trow;
        c.tcol        = tcol;
        c.drain_first = 1'b0;
        return c;
    endfunction

    // weighted mix; clear and scroll walk the whole store so they stay rare,
    // and frequent set-position commands keep the cursor away from the bottom
    function automatic t_console_cmd random_cmd();
        t_console_cmd c;
        int pick;
        c = make_cmd(F_DRAW, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            c.func = F_DRAW;
        end else if (pick < 36) begin
            c.func = F_ADVANCE;
            if ($urandom_range(0, 3) != 0)
                c.count = 8'($urandom_range(0, 12));
        end else if (pick < 46) begin
            c.func = F_RETREAT;
            if ($urandom_range(0, 1) != 0)
                c.count = 8'($urandom_range(0, 12));
        end else if (pick < 52) begin
            c.func = F_NEWLINE;
        end else if (pick < 60) begin
            c.func = F_TAB;
        end else if (pick < 62) begin
            c.func = F_CLEAR;
        end else if (pick < 64) begin
            c.func = F_SCROLL;
        end else if (pick < 78) begin
            c.func = F_SETPOS;
            if ($urandom_range(0, 9) < 7) begin
                c.trow = 5'($urandom_range(0, 20));
                c.tcol = 7'($urandom_range(0, COLS - 1));
            end
        end else if (pick < 94) begin
            c.func = F_READ;
            if ($urandom_range(0, 1) != 0) begin
                c.trow = 5'($urandom_range(0, ROWS - 1));
                c.tcol = 7'($urandom_range(0, COLS - 1));
            end
        end else begin
            // codes above read cell
            c.func = t_func'($urandom_range(9, 15));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued commands, idles in bursts, holds while stalled
    // ------------------------------------------------------------------
    t_console_cmd in_flight;
    int           send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            // transaction accepted at this edge: predict its result now
            if (i_valid && !o_stall) begin
                expected_results.push_back(console_apply(in_flight));
                sent_count++;
            end
            if (i_valid && o_stall) begin
                // stalled: payload and valid stay put
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap--;
            end else if (pending_cmds.size() == 0 ||
                         (pending_cmds[0].drain_first && expected_results.size() != 0)) begin
                // nothing left, or waiting for the block to drain completely
                i_valid <= 1'b0;
            end else begin
                in_flight = pending_cmds.pop_front();
                i_valid      <= 1'b1;
                i_func       <= in_flight.func;
                i_char_code  <= in_flight.ch;
                i_color_attr <= in_flight.attr;
                i_move_count <= in_flight.count;
                i_target_row <= in_flight.trow;
                i_target_col <= in_flight.tcol;
                // idle burst after this transaction, except in the quiet tail
                if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 19);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: stalls in bursts, checks every accepted result in order
    // ------------------------------------------------------------------
    t_console_result oldest;
    int              stall_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_gap = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding, cursor",
                                    int'({o_cursor_row, o_cursor_col}), 0);
                end else begin
                    oldest = expected_results.pop_front();
                    if (o_cursor_row !== oldest.row)
                        report_mismatch("cursor_row", int'(o_cursor_row), int'(oldest.row));
                    if (o_cursor_col !== oldest.col)
                        report_mismatch("cursor_col", int'(o_cursor_col), int'(oldest.col));
                    if (o_cell_value !== oldest.cell_value)
                        report_mismatch("cell_value", int'(o_cell_value),
                                        int'(oldest.cell_value));
                end
            end
            if (stall_gap > 0) begin
                i_stall <= 1'b1;
                stall_gap--;
            end else begin
                i_stall <= 1'b0;
                if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0)
                    stall_gap = $urandom_range(1, 19);
            end
        end
    end

    // ------------------------------------------------------------------
    // command stream, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        t_console_cmd c;
        int i;

        // shadow store content before any write is never observed
        for (i = 0; i < CELLS; i++)
            shadow_cells[i] = '0;
        shadow_row = 0;
        shadow_col = 0;

        // directed part
        // only the home cell is written before the first clear, so only it is read
        pending_cmds.push_back(make_cmd(F_DRAW, 8'hFF, 8'hFF, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_READ, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        // from here on every cell is written, scrolls keep it so
        pending_cmds.push_back(make_cmd(F_CLEAR, 8'h00, 8'h5A, 8'h00, 5'd0, 7'd0));
        // last cell: draw, read back, then overflow by four rows in one advance
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd24, 7'd79));
        pending_cmds.push_back(make_cmd(F_DRAW, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_READ, 8'h00, 8'h00, 8'h00, 5'd24, 7'd79));
        pending_cmds.push_back(make_cmd(F_ADVANCE, 8'h00, 8'h00, 8'hFF, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_READ, 8'h00, 8'h00, 8'h00, 5'd20, 7'd79));
        // targets beyond the store saturate at the last cell
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd31, 7'd127));
        pending_cmds.push_back(make_cmd(F_READ, 8'h00, 8'h00, 8'h00, 5'd31, 7'd127));
        // a column past the row end wraps into the rows below
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd3, 7'd127));
        pending_cmds.push_back(make_cmd(F_TAB, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        // tab near the row end wraps to the next row
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd10, 7'd77));
        pending_cmds.push_back(make_cmd(F_TAB, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        // zero-length moves
        pending_cmds.push_back(make_cmd(F_RETREAT, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_ADVANCE, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        // retreat above the top row goes home
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd0, 7'd5));
        pending_cmds.push_back(make_cmd(F_RETREAT, 8'h00, 8'h00, 8'hC8, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_NEWLINE, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        // newline on the bottom row scrolls
        pending_cmds.push_back(make_cmd(F_SETPOS, 8'h00, 8'h00, 8'h00, 5'd24, 7'd10));
        pending_cmds.push_back(make_cmd(F_NEWLINE, 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_SCROLL, 8'h00, 8'hC3, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_READ, 8'h00, 8'h00, 8'h00, 5'd24, 7'd0));
        // unused codes, the first one only after the block has fully drained
        c = make_cmd(t_func'(4'd9), 8'hA5, 8'h5A, 8'h3C, 5'd17, 7'd99);
        c.drain_first = 1'b1;
        pending_cmds.push_back(c);
        pending_cmds.push_back(make_cmd(t_func'(4'd15), 8'h00, 8'h00, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(F_CLEAR, 8'h00, 8'hFF, 8'h00, 5'd0, 7'd0));

        // random part, with a couple more full drains along the way
        for (i = 0; i < RANDOM_CMDS; i++) begin
            c = random_cmd();
            if (i == RANDOM_CMDS / 3 || i == 2 * RANDOM_CMDS / 3)
                c.drain_first = 1'b1;
            pending_cmds.push_back(c);
        end
        total_cmds = pending_cmds.size();

        // single synchronous reset at the start
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all commands accepted and all results back
        while (sent_count != total_cmds || expected_results.size() != 0)
            @(posedge i_clk);
        // short tail to catch stray results
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("text_console_cursor_engine test passed");
        else
            $display("text_console_cursor_engine test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #150_000_000;
        $display("text_console_cursor_engine test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/tcce_dpath.sv
hw/rtl/text_console_cursor_engine.sv
dv/tb.sv
